/* sv/psfp_pkg.sv */
// shared constants for the particle sensor frame parser
package psfp_pkg;

  localparam int unsigned FRAME_LEN = 20;
  localparam int unsigned NUM_CELLS = FRAME_LEN - 1;
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] SUM_FIRST = POS_W'(2);
  localparam logic [POS_W-1:0] SUM_LAST = POS_W'(17);

  localparam logic [7:0] HDR0 = 8'h4A;
  localparam logic [7:0] HDR1 = 8'h43;
  localparam logic [7:0] FOOTER = 8'h0D;
  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

  localparam logic [31:0] MASS_LIMIT_RESET = 32'h461C4000;
  localparam logic [31:0] COUNT_LIMIT_RESET = 32'h49742400;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 1'b1;

  localparam int unsigned STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FRAMING = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PM1 = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PM25 = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PM10 = 3'd5;
  localparam logic [STATUS_W-1:0] ST_COUNT = 3'd6;

  localparam int unsigned OUT_BITS = STATUS_W + 4 * 32;
  localparam int unsigned OUT_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

/* sv/psfp_byte_cell.sv */
// one byte cell of the frame shift chain
module psfp_byte_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

/* sv/psfp_value_check.sv */
// range check of one ieee single pattern against a limit pattern
module psfp_value_check (
  input  logic [31:0] value,
  input  logic [31:0] limit,
  output logic        ok
);

  logic [30:0] mag;
  logic [30:0] lmag;
  logic        limit_nan;

  assign mag = value[30:0];
  assign lmag = limit[30:0];
  assign limit_nan = (limit[30:23] == psfp_pkg::EXP_ALL_ONES) && (limit[22:0] != 23'd0);

  always_comb begin
    if (value[30:23] == psfp_pkg::EXP_ALL_ONES) begin
      ok = 1'b0;
    end else if (value[31] && (mag != 31'd0)) begin
      ok = 1'b0;
    end else if (limit_nan) begin
      ok = 1'b1;
    end else if (limit[31]) begin
      ok = (mag == 31'd0) && (lmag == 31'd0);
    end else begin
      ok = (mag <= lmag);
    end
  end

endmodule

/* sv/particle_sensor_frame_parser_top.sv */
// top level of the particle sensor frame parser
// the result item becomes valid in the cycle after the twentieth byte of a frame is accepted
// throughput: one byte item per cycle while the result side does not stall; one result item per twenty bytes
// rate is set by the result side handshake; the byte shift chain moves one cell per accepted item
// reset: synchronous active high; clears byte position, checksum, output valid and
// loads the default limit patterns
module particle_sensor_frame_parser_top #(
  parameter logic [31:0] MASS_LIMIT_INIT = psfp_pkg::MASS_LIMIT_RESET,
  parameter logic [31:0] COUNT_LIMIT_INIT = psfp_pkg::COUNT_LIMIT_RESET
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // rx_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status[2:0], pm1_bits[34:3], pm25_bits[66:35], pm10_bits[98:67], count_bits[130:99]
  output logic [psfp_pkg::OUT_W-1:0]         m_tdata,
  input  logic                               cfg_we,
  input  logic [psfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int unsigned NC = psfp_pkg::NUM_CELLS;

  logic [31:0]               mass_limit;
  logic [31:0]               count_limit;
  logic [psfp_pkg::POS_W-1:0] pos;
  logic [7:0]                sum;
  logic                      in_acc;
  logic                      last_byte;
  logic [7:0]                cell_q [NC];
  logic [31:0]               pm1;
  logic [31:0]               pm25;
  logic [31:0]               pm10;
  logic [31:0]               cnt;
  logic                      pm1_ok;
  logic                      pm25_ok;
  logic                      pm10_ok;
  logic                      cnt_ok;
  logic [psfp_pkg::STATUS_W-1:0] status_next;

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc = s_tvalid && s_tready;
  assign last_byte = (pos >= psfp_pkg::LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_limit <= MASS_LIMIT_INIT;
      count_limit <= COUNT_LIMIT_INIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psfp_pkg::REG_MASS_LIMIT:  mass_limit <= cfg_data;
        psfp_pkg::REG_COUNT_LIMIT: count_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NC; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        psfp_byte_cell u_cell (
          .clk   (clk),
          .shift (in_acc),
          .d     (s_tdata),
          .q     (cell_q[gi])
        );
      end else begin : g_body
        psfp_byte_cell u_cell (
          .clk   (clk),
          .shift (in_acc),
          .d     (cell_q[gi-1]),
          .q     (cell_q[gi])
        );
      end
    end
  endgenerate

  // byte k of the frame sits in cell NC-1-k when the footer arrives
  assign pm25 = {cell_q[13], cell_q[14], cell_q[15], cell_q[16]};
  assign pm10 = {cell_q[9], cell_q[10], cell_q[11], cell_q[12]};
  assign pm1 = {cell_q[5], cell_q[6], cell_q[7], cell_q[8]};
  assign cnt = {cell_q[1], cell_q[2], cell_q[3], cell_q[4]};

  psfp_value_check u_chk_pm1 (.value(pm1), .limit(mass_limit), .ok(pm1_ok));
  psfp_value_check u_chk_pm25 (.value(pm25), .limit(mass_limit), .ok(pm25_ok));
  psfp_value_check u_chk_pm10 (.value(pm10), .limit(mass_limit), .ok(pm10_ok));
  psfp_value_check u_chk_cnt (.value(cnt), .limit(count_limit), .ok(cnt_ok));

  always_comb begin
    if (cell_q[NC-1] != psfp_pkg::HDR0 || cell_q[NC-2] != psfp_pkg::HDR1
        || s_tdata != psfp_pkg::FOOTER) begin
      status_next = psfp_pkg::ST_FRAMING;
    end else if (sum != cell_q[0]) begin
      status_next = psfp_pkg::ST_CHECKSUM;
    end else if (!pm1_ok) begin
      status_next = psfp_pkg::ST_PM1;
    end else if (!pm25_ok) begin
      status_next = psfp_pkg::ST_PM25;
    end else if (!pm10_ok) begin
      status_next = psfp_pkg::ST_PM10;
    end else if (!cnt_ok) begin
      status_next = psfp_pkg::ST_COUNT;
    end else begin
      status_next = psfp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
    end else if (in_acc) begin
      if (last_byte) begin
        pos <= '0;
        sum <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (pos >= psfp_pkg::SUM_FIRST && pos <= psfp_pkg::SUM_LAST) begin
          sum <= sum + s_tdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc && last_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_byte) begin
      m_tdata <= psfp_pkg::OUT_W'({cnt, pm10, pm25, pm1, status_next});
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= psfp_pkg::LAST_POS)
    else $error("byte position past end of frame");

  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    (pos <= psfp_pkg::SUM_FIRST) |-> (sum == 8'd0))
    else $error("checksum not clear at frame start");

  a_result_after_footer: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last_byte) |=> m_tvalid)
    else $error("no result item after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_acc && last_byte))
    else $error("result item without a finished frame");

endmodule

/* tb/sv/psfp_frame_checker.sv */
// frame checker: predicts the status of each sensor frame and compares the result items
module psfp_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [psfp_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           cfg_we,
  input  logic [psfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int unsigned                    mismatches,
  output int unsigned                    reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [psfp_pkg::STATUS_W-1:0] status;
    logic [31:0]                   pm1;
    logic [31:0]                   pm25;
    logic [31:0]                   pm10;
    logic [31:0]                   count;
  } frame_report_t;

  frame_report_t frame_reports_q[$];

  logic [31:0] mass_limit;
  logic [31:0] count_limit;
  int unsigned byte_pos;
  logic [7:0]  cells [psfp_pkg::FRAME_LEN];
  logic [7:0]  body_sum;

  function automatic logic [31:0] word_from(int unsigned base);
    return {cells[base + 3], cells[base + 2], cells[base + 1], cells[base]};
  endfunction

  // finite, not negative (minus zero allowed) and not above the limit
  function automatic logic reading_passes(logic [31:0] v, logic [31:0] lim);
    if (v[30:23] == psfp_pkg::EXP_ALL_ONES) return 1'b0;
    if (v[31] && v[30:0] != '0) return 1'b0;
    if (lim[30:23] == psfp_pkg::EXP_ALL_ONES && lim[22:0] != '0) return 1'b1;
    if (lim[31]) return v[30:0] == '0 && lim[30:0] == '0;
    return v[30:0] <= lim[30:0];
  endfunction

  function automatic frame_report_t judge_frame();
    frame_report_t r;
    r.pm25 = word_from(2);
    r.pm10 = word_from(6);
    r.pm1 = word_from(10);
    r.count = word_from(14);
    if (cells[0] != psfp_pkg::HDR0 || cells[1] != psfp_pkg::HDR1
        || cells[psfp_pkg::FRAME_LEN-1] != psfp_pkg::FOOTER) r.status = psfp_pkg::ST_FRAMING;
    else if (body_sum != cells[psfp_pkg::FRAME_LEN-2]) r.status = psfp_pkg::ST_CHECKSUM;
    else if (!reading_passes(r.pm1, mass_limit)) r.status = psfp_pkg::ST_PM1;
    else if (!reading_passes(r.pm25, mass_limit)) r.status = psfp_pkg::ST_PM25;
    else if (!reading_passes(r.pm10, mass_limit)) r.status = psfp_pkg::ST_PM10;
    else if (!reading_passes(r.count, count_limit)) r.status = psfp_pkg::ST_COUNT;
    else r.status = psfp_pkg::ST_OK;
    return r;
  endfunction

  task automatic take_byte(logic [7:0] b);
    cells[byte_pos] = b;
    if (byte_pos >= psfp_pkg::NUM_CELLS) begin
      frame_reports_q.push_back(judge_frame());
      byte_pos = 0;
      body_sum = '0;
    end else begin
      if (byte_pos >= psfp_pkg::SUM_FIRST && byte_pos <= psfp_pkg::SUM_LAST) begin
        body_sum = body_sum + b;
      end
      byte_pos = byte_pos + 1;
    end
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (rst) begin
      frame_reports_q.delete();
      mass_limit = psfp_pkg::MASS_LIMIT_RESET;
      count_limit = psfp_pkg::COUNT_LIMIT_RESET;
      byte_pos = 0;
      body_sum = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[2:0];
        got.pm1 = m_tdata[34:3];
        got.pm25 = m_tdata[66:35];
        got.pm10 = m_tdata[98:67];
        got.count = m_tdata[130:99];
        if (frame_reports_q.size() == 0) begin
          $error("result item with no frame pending: status %0d", got.status);
          mismatches++;
        end else begin
          want = frame_reports_q.pop_front();
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("pm1_bits", want.pm1, got.pm1);
          compare_field("pm25_bits", want.pm25, got.pm25);
          compare_field("pm10_bits", want.pm10, got.pm10);
          compare_field("count_bits", want.count, got.count);
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata);
      if (cfg_we) begin
        case (cfg_index)
          psfp_pkg::REG_MASS_LIMIT: mass_limit = cfg_data;
          psfp_pkg::REG_COUNT_LIMIT: count_limit = cfg_data;
          default: ;
        endcase
      end
    end
    reports_pending = frame_reports_q.size();
  end

endmodule

/* tb/sv/tb_particle_sensor_frame_parser_top.sv */
// testbench top: byte stimulus, limit settings and verdict for the frame parser
module tb_particle_sensor_frame_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;   // rx_byte
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // status[2:0], pm1_bits[34:3], pm25_bits[66:35], pm10_bits[98:67], count_bits[130:99]
  logic [psfp_pkg::OUT_W-1:0]     m_tdata;
  logic                           cfg_we = 1'b0;
  logic [psfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;

  int unsigned mismatches;
  int unsigned reports_pending;

  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  logic [31:0] mass_lim = psfp_pkg::MASS_LIMIT_RESET;
  logic [31:0] count_lim = psfp_pkg::COUNT_LIMIT_RESET;
  logic [7:0]  frame_buf [psfp_pkg::FRAME_LEN];

  particle_sensor_frame_parser_top i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  psfp_frame_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .reports_pending
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // result side stalls
  initial begin
    int unsigned stall;
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic send_frame();
    for (int i = 0; i < psfp_pkg::FRAME_LEN; i++) send_byte(frame_buf[i]);
  endtask

  task automatic load_frame(logic [31:0] pm25, logic [31:0] pm10, logic [31:0] pm1,
                            logic [31:0] cnt);
    logic [7:0] sum;
    frame_buf[0] = psfp_pkg::HDR0;
    frame_buf[1] = psfp_pkg::HDR1;
    for (int k = 0; k < 4; k++) begin
      frame_buf[2 + k] = pm25[8*k +: 8];
      frame_buf[6 + k] = pm10[8*k +: 8];
      frame_buf[10 + k] = pm1[8*k +: 8];
      frame_buf[14 + k] = cnt[8*k +: 8];
    end
    sum = '0;
    for (int i = psfp_pkg::SUM_FIRST; i <= psfp_pkg::SUM_LAST; i++) sum = sum + frame_buf[i];
    frame_buf[psfp_pkg::FRAME_LEN-2] = sum;
    frame_buf[psfp_pkg::FRAME_LEN-1] = psfp_pkg::FOOTER;
  endtask

  task automatic send_readings(logic [31:0] pm25, logic [31:0] pm10, logic [31:0] pm1,
                               logic [31:0] cnt);
    load_frame(pm25, pm10, pm1, cnt);
    send_frame();
  endtask

  // float pattern around a limit; calm draws stay in the passing range when the limit is finite and has one
  function automatic logic [31:0] pick_reading(logic [31:0] lim, logic calm);
    int unsigned kind;
    logic [30:0] mag;
    mag = lim[30:0];
    kind = calm ? $urandom_range(0, 5) : $urandom_range(0, 13);
    case (kind)
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'b0, mag};
      3, 4, 5: return {1'b0, 31'($urandom_range(0, mag))};
      6: return {1'b0, mag} + 32'd1;
      7: return {9'b0, 23'($urandom)};
      8: return {1'($urandom), psfp_pkg::EXP_ALL_ONES, 23'($urandom)};
      9: return {1'($urandom), psfp_pkg::EXP_ALL_ONES, 23'b0};
      10: return {1'b1, 31'($urandom)};
      11: return {1'b0, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned hit;
    logic        calm;
    kind = $urandom_range(0, 9);
    calm = (kind >= 6);
    load_frame(pick_reading(mass_lim, calm), pick_reading(mass_lim, calm),
               pick_reading(mass_lim, calm), pick_reading(count_lim, calm));
    case (kind)
      0: for (int i = 0; i < psfp_pkg::FRAME_LEN; i++) frame_buf[i] = 8'($urandom);
      1: begin
        hit = $urandom_range(0, 2);
        hit = (hit == 2) ? psfp_pkg::FRAME_LEN - 1 : hit;
        frame_buf[hit] = frame_buf[hit] ^ 8'($urandom_range(1, 255));
      end
      2: begin
        frame_buf[psfp_pkg::FRAME_LEN-2] =
          frame_buf[psfp_pkg::FRAME_LEN-2] ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    send_frame();
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [psfp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(logic [31:0] mass, logic [31:0] cnt);
    mass_lim = mass;
    count_lim = cnt;
    write_reg(psfp_pkg::REG_MASS_LIMIT, mass);
    write_reg(psfp_pkg::REG_COUNT_LIMIT, cnt);
  endtask

  initial begin
    logic [31:0] phase_mass [7];
    logic [31:0] phase_count [7];
    int unsigned waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames at the reset limits
    rx_calm = 1'b0;
    tx_calm = 1'b1;
    send_readings('0, '0, '0, '0);
    send_readings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_readings(mass_lim, mass_lim, mass_lim, count_lim);
    tx_calm = 1'b0;
    send_readings(32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h0000_0001);
    load_frame('0, '0, '0, '0);
    frame_buf[0] = 8'hB5;
    send_frame();
    load_frame('0, '0, '0, '0);
    frame_buf[1] = 8'hBC;
    send_frame();
    load_frame('0, '0, '0, '0);
    frame_buf[psfp_pkg::FRAME_LEN-1] = 8'hF2;
    send_frame();
    load_frame(32'h3F80_0000, '0, '0, '0);
    frame_buf[psfp_pkg::FRAME_LEN-2] = frame_buf[psfp_pkg::FRAME_LEN-2] ^ 8'h01;
    send_frame();
    load_frame('0, '0, 32'h7FC0_0001, '0);
    frame_buf[0] = 8'h00;
    frame_buf[psfp_pkg::FRAME_LEN-2] = frame_buf[psfp_pkg::FRAME_LEN-2] ^ 8'h80;
    send_frame();
    load_frame('0, '0, 32'h7FC0_0001, '0);
    frame_buf[psfp_pkg::FRAME_LEN-2] = frame_buf[psfp_pkg::FRAME_LEN-2] ^ 8'h10;
    send_frame();
    send_readings('0, '0, 32'h7FC0_0001, '0);
    send_readings(32'h7F80_0000, '0, '0, '0);
    send_readings('0, 32'hBF80_0000, '0, '0);
    send_readings('0, mass_lim + 32'd1, '0, '0);
    send_readings('0, '0, '0, count_lim + 32'd1);
    send_readings('0, '0, '0, 32'hFF80_0000);
    for (int i = 0; i < psfp_pkg::FRAME_LEN; i++) frame_buf[i] = 8'hFF;
    send_frame();
    for (int i = 0; i < psfp_pkg::FRAME_LEN; i++) frame_buf[i] = 8'h00;
    send_frame();
    wait_idle();

    // limit settings: defaults, zero, all ones, infinities, negatives, nan, random, one and the smallest normal
    phase_mass[0] = psfp_pkg::MASS_LIMIT_RESET;
    phase_count[0] = psfp_pkg::COUNT_LIMIT_RESET;
    phase_mass[1] = 32'h0000_0000;      phase_count[1] = 32'h0000_0000;
    phase_mass[2] = 32'hFFFF_FFFF;      phase_count[2] = 32'h7F80_0000;
    phase_mass[3] = 32'h7F80_0000;      phase_count[3] = 32'h8000_0000;
    phase_mass[4] = 32'hBF80_0000;      phase_count[4] = 32'h7FC0_0000;
    phase_mass[5] = {1'b0, 31'($urandom_range(0, 32'h7F7F_FFFF))};
    phase_count[5] = $urandom;
    phase_mass[6] = 32'h3F80_0000;      phase_count[6] = 32'h0080_0000;

    for (int p = 0; p < 7; p++) begin
      set_limits(phase_mass[p], phase_count[p]);
      rx_calm = ($urandom_range(0, 2) == 0);
      tx_calm = ($urandom_range(0, 2) == 0);
      send_random_frame();
      wait_idle();
    end

    waited = 0;
    while (reports_pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0 && reports_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
